[src/assert_macros.svh]
// Assertion shorthands for the checker modules.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, masked while reset is asserted
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Condition that must hold in the cycle after reset is sampled
`define ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("post-reset check failed");

`endif

[src/bqpc_pkg.sv]
package bqpc_pkg;

  // Field widths
  localparam int COUNT_W = 24;
  localparam int CMD_W   = 25;
  localparam int DUTY_W  = 16;
  localparam int COEF_W  = 16;
  localparam int POS_W   = 32;
  localparam int VLIM_W  = 24;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;

  // Sequencing counts
  localparam int MAC_TERMS = 5;
  localparam int DIV_STEPS = 8;
  localparam int CNT_W     = 3;

  // Register reset values
  localparam logic signed [COEF_W-1:0] RST_B0   = 16'sd6144;
  localparam logic signed [COEF_W-1:0] RST_B1   = -16'sd9421;
  localparam logic signed [COEF_W-1:0] RST_B2   = 16'sd3686;
  localparam logic signed [COEF_W-1:0] RST_A1   = -16'sd5734;
  localparam logic signed [COEF_W-1:0] RST_A2   = 16'sd2048;
  localparam logic signed [POS_W-1:0]  RST_SP   = 32'sd65536;
  localparam logic [VLIM_W-1:0]        RST_VLIM = 24'd786432;
  localparam logic [CFG_W-1:0]         RST_RPC  = 32'd6588397;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_A1,
    REG_A2,
    REG_SETPOINT,
    REG_VLIMIT,
    REG_RPC
  } bqpc_reg_idx_t;

  // Operand pair routed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_POS,
    MUL_B0,
    MUL_B1,
    MUL_B2,
    MUL_A1,
    MUL_A2
  } bqpc_mul_sel_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_ERR,
    ST_MAC,
    ST_MAC_LAST,
    ST_CLAMP,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } bqpc_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic          ld_in;
    logic          mul_en;
    bqpc_mul_sel_t mul_sel;
    logic          err_en;
    logic          acc_clr;
    logic          acc_en;
    logic          clamp_en;
    logic          div_init;
    logic          div_step;
    logic          out_load;
  } bqpc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } bqpc_status_t;

endpackage

[src/bqpc_ctrl.sv]
module bqpc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bqpc_pkg::bqpc_status_t status,
  output bqpc_pkg::bqpc_cmd_t    cmd
);
  import bqpc_pkg::*;

  localparam logic [CNT_W-1:0] MAC_LAST_IDX = CNT_W'(MAC_TERMS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST_IDX = CNT_W'(DIV_STEPS - 1);

  bqpc_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Take a new transaction only when idle
  assign in_stall = (state_r != ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mul_sel = MUL_POS;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_POS;
        end
      end
      ST_POS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_POS;
        state_nxt   = ST_ERR;
      end
      ST_ERR: begin
        cmd.err_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_MAC;
      end
      ST_MAC: begin
        // issue one product per cycle, accumulate the one issued before
        cmd.mul_en = 1'b1;
        cmd.acc_en = (cnt_r != '0);
        case (cnt_r)
          3'd0:    cmd.mul_sel = MUL_B0;
          3'd1:    cmd.mul_sel = MUL_B1;
          3'd2:    cmd.mul_sel = MUL_B2;
          3'd3:    cmd.mul_sel = MUL_A1;
          default: cmd.mul_sel = MUL_A2;
        endcase
        if (cnt_r == MAC_LAST_IDX) begin
          state_nxt = ST_MAC_LAST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MAC_LAST: begin
        cmd.acc_en = 1'b1;
        state_nxt  = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp_en = 1'b1;
        state_nxt    = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST_IDX) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[src/bqpc_dp.sv]
module bqpc_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [bqpc_pkg::IDX_W-1:0]            cfg_index,
  input  logic [bqpc_pkg::CFG_W-1:0]            cfg_wr_data,
  input  logic signed [bqpc_pkg::COUNT_W-1:0]   in_count_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bqpc_pkg::CMD_W-1:0]     out_command,
  output logic signed [bqpc_pkg::DUTY_W-1:0]    out_duty,
  output logic                                  out_clipped,
  input  bqpc_pkg::bqpc_cmd_t                   cmd,
  output bqpc_pkg::bqpc_status_t                status
);
  import bqpc_pkg::*;

  localparam int OPA_W  = POS_W + 1;
  localparam int OPB_W  = POS_W;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 50;
  localparam int FRAC_S = 16;
  localparam int COEF_S = 12;
  localparam int PW_W   = COUNT_W + POS_W - FRAC_S;
  localparam int UW_W   = ACC_W - COEF_S;
  localparam int QW     = DUTY_W;

  // Configuration registers
  logic signed [COEF_W-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [POS_W-1:0]  sp_r;
  logic [VLIM_W-1:0]        vlim_r;
  logic [CFG_W-1:0]         rpc_r;

  // Filter history
  logic signed [POS_W-1:0]  e1_r, e2_r;
  logic signed [CMD_W-1:0]  c1_r, c2_r;

  // Working registers
  logic signed [COUNT_W-1:0] count_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [POS_W-1:0]   err_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [CMD_W-1:0]   u_r;
  logic                      clip_r;
  logic [VLIM_W-1:0]         rem_r;
  logic [QW-1:0]             dbits_r;
  logic [QW-1:0]             q_r;

  // Output register
  logic                      out_valid_r;
  logic signed [CMD_W-1:0]   out_command_r;
  logic signed [DUTY_W-1:0]  out_duty_r;
  logic                      out_clipped_r;

  // One restoring division step: returns {quotient bit, remainder}
  function automatic logic [VLIM_W:0] div_bit(input logic [VLIM_W-1:0] rem,
                                               input logic bin,
                                               input logic [VLIM_W-1:0] d);
    logic [VLIM_W:0] t;
    logic [VLIM_W:0] diff;
    t    = {rem, bin};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_bit = {1'b1, diff[VLIM_W-1:0]};
    end else begin
      div_bit = {1'b0, t[VLIM_W-1:0]};
    end
  endfunction

  // Shared multiplier operand selection
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] mul_res;

  always_comb begin
    case (cmd.mul_sel)
      MUL_POS: begin
        op_a = $signed({1'b0, rpc_r});
        op_b = OPB_W'(count_r);
      end
      MUL_B0: begin
        op_a = OPA_W'(err_r);
        op_b = OPB_W'(b0_r);
      end
      MUL_B1: begin
        op_a = OPA_W'(e1_r);
        op_b = OPB_W'(b1_r);
      end
      MUL_B2: begin
        op_a = OPA_W'(e2_r);
        op_b = OPB_W'(b2_r);
      end
      MUL_A1: begin
        op_a = OPA_W'(c1_r);
        op_b = -OPB_W'(a1_r);
      end
      MUL_A2: begin
        op_a = OPA_W'(c2_r);
        op_b = -OPB_W'(a2_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_res = op_a * op_b;

  // Position: floor to Q16.16, saturate to 32 bits; error: saturating subtract
  logic signed [PW_W-1:0]  pos_wide;
  logic signed [POS_W-1:0] pos_sat;
  logic signed [POS_W:0]   err_wide;
  logic signed [POS_W-1:0] err_sat;

  always_comb begin
    pos_wide = prod_r[COUNT_W+POS_W-1:FRAC_S];
    if (pos_wide[PW_W-1:POS_W-1] == '0 || pos_wide[PW_W-1:POS_W-1] == '1) begin
      pos_sat = pos_wide[POS_W-1:0];
    end else if (pos_wide[PW_W-1]) begin
      pos_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
    err_wide = (POS_W+1)'(sp_r) - (POS_W+1)'(pos_sat);
    if (err_wide[POS_W] == err_wide[POS_W-1]) begin
      err_sat = err_wide[POS_W-1:0];
    end else if (err_wide[POS_W]) begin
      err_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      err_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // Floor the sum to Q8.16 and clamp to the voltage limit
  logic signed [UW_W:0]    u_ext;
  logic signed [UW_W:0]    vlim_pos;
  logic signed [CMD_W-1:0] u_clamped;
  logic                    clip_nxt;

  always_comb begin
    u_ext    = (UW_W+1)'($signed(acc_r[ACC_W-1:COEF_S]));
    vlim_pos = $signed((UW_W+1)'(vlim_r));
    clip_nxt = 1'b0;
    u_clamped = u_ext[CMD_W-1:0];
    if (u_ext > vlim_pos) begin
      u_clamped = $signed({1'b0, vlim_r});
      clip_nxt  = 1'b1;
    end else if (u_ext < -vlim_pos) begin
      u_clamped = -$signed({1'b0, vlim_r});
      clip_nxt  = 1'b1;
    end
  end

  // Divider: magnitude setup and two quotient bits per step
  logic [CMD_W-1:0]  mag_full;
  logic [VLIM_W:0]   div_s1, div_s2;

  assign mag_full = u_r[CMD_W-1] ? CMD_W'(-u_r) : CMD_W'(u_r);
  assign div_s1   = div_bit(rem_r, dbits_r[QW-1], vlim_r);
  assign div_s2   = div_bit(div_s1[VLIM_W-1:0], dbits_r[QW-2], vlim_r);

  // Duty from quotient: clamp, restore sign, zero for a zero limit
  logic [DUTY_W-2:0]        duty_mag;
  logic signed [DUTY_W-1:0] duty_val;

  always_comb begin
    duty_mag = q_r[QW-1] ? {(DUTY_W-1){1'b1}} : q_r[DUTY_W-2:0];
    if (vlim_r == '0) begin
      duty_val = '0;
    end else if (u_r[CMD_W-1]) begin
      duty_val = -$signed({1'b0, duty_mag});
    end else begin
      duty_val = $signed({1'b0, duty_mag});
    end
  end

  // Configuration registers, history and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r        <= RST_B0;
      b1_r        <= RST_B1;
      b2_r        <= RST_B2;
      a1_r        <= RST_A1;
      a2_r        <= RST_A2;
      sp_r        <= RST_SP;
      vlim_r      <= RST_VLIM;
      rpc_r       <= RST_RPC;
      e1_r        <= '0;
      e2_r        <= '0;
      c1_r        <= '0;
      c2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (bqpc_reg_idx_t'(cfg_index))
          REG_B0:       b0_r   <= cfg_wr_data[COEF_W-1:0];
          REG_B1:       b1_r   <= cfg_wr_data[COEF_W-1:0];
          REG_B2:       b2_r   <= cfg_wr_data[COEF_W-1:0];
          REG_A1:       a1_r   <= cfg_wr_data[COEF_W-1:0];
          REG_A2:       a2_r   <= cfg_wr_data[COEF_W-1:0];
          REG_SETPOINT: sp_r   <= cfg_wr_data[POS_W-1:0];
          REG_VLIMIT:   vlim_r <= cfg_wr_data[VLIM_W-1:0];
          REG_RPC:      rpc_r  <= cfg_wr_data;
          default: begin
          end
        endcase
      end
      // advance history once the new command is known
      if (cmd.clamp_en) begin
        e2_r <= e1_r;
        e1_r <= err_r;
        c2_r <= c1_r;
        c1_r <= u_clamped;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      count_r <= in_count_sample;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_res;
    end
    if (cmd.err_en) begin
      err_r <= err_sat;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + prod_r[ACC_W-1:0];
    end
    if (cmd.clamp_en) begin
      u_r    <= u_clamped;
      clip_r <= clip_nxt;
    end
    if (cmd.div_init) begin
      rem_r   <= {1'b0, mag_full[VLIM_W-1:1]};
      dbits_r <= {mag_full[0], {(QW-1){1'b0}}};
      q_r     <= '0;
    end else if (cmd.div_step) begin
      rem_r   <= div_s2[VLIM_W-1:0];
      dbits_r <= {dbits_r[QW-3:0], 2'b00};
      q_r     <= {q_r[QW-3:0], div_s1[VLIM_W], div_s2[VLIM_W]};
    end
    if (cmd.out_load) begin
      out_command_r <= u_r;
      out_duty_r    <= duty_val;
      out_clipped_r <= clip_r;
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_command = out_command_r;
  assign out_duty    = out_duty_r;
  assign out_clipped = out_clipped_r;

endmodule

[src/biquad_position_controller.sv]
// Each accepted transaction runs to completion before the next one is taken; six passes
// through the shared 33x32 multiplier and eight 2-bit steps of the duty divider make up
// the work, and the result waits until the output register can take it.
// A finished result sits in the output register while the next sample is taken.
// Reset (rst_n low, synchronous): configuration registers return to their defaults,
// filter history clears to zero and the output register empties.
module biquad_position_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [bqpc_pkg::COUNT_W-1:0] in_count_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bqpc_pkg::CMD_W-1:0]   out_command,
  output logic signed [bqpc_pkg::DUTY_W-1:0]  out_duty,
  output logic                                out_clipped,
  input  logic                                cfg_wr_en,
  input  logic [bqpc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [bqpc_pkg::CFG_W-1:0]          cfg_wr_data
);
  import bqpc_pkg::*;

  bqpc_cmd_t    cmd;
  bqpc_status_t status;

  // Sequencer
  bqpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic, configuration and output register
  bqpc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .in_count_sample (in_count_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_command     (out_command),
    .out_duty        (out_duty),
    .out_clipped     (out_clipped),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

[src/bqpc_checker.sv]
`include "assert_macros.svh"

module bqpc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [bqpc_pkg::CMD_W-1:0]   out_command,
  input logic signed [bqpc_pkg::DUTY_W-1:0]  out_duty,
  input logic                                out_clipped
);
  import bqpc_pkg::*;

  // Output stays presented while stalled
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // Busy after taking a sample: no second transaction in the next cycle
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // A non-negative command never drives a negative duty
  `ASSERT_IMPL(a_duty_sign, out_valid && !out_command[CMD_W-1], !out_duty[DUTY_W-1])

  // A clipped command drives full-scale duty, or zero for a zero limit
  `ASSERT_IMPL(a_clip_full_duty, out_valid && out_clipped, out_duty == 16'sd32767 || out_duty == -16'sd32767 || out_duty == 16'sd0)

  // Output register is empty after reset
  `ASSERT_AFTER_RESET(a_reset_empty, !out_valid)

endmodule

bind biquad_position_controller bqpc_checker u_bqpc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_command (out_command),
  .out_duty    (out_duty),
  .out_clipped (out_clipped)
);

[tb/tb_biquad_position_controller.sv]
module tb_biquad_position_controller;
  import bqpc_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 92;

  typedef struct packed {
    logic signed [CMD_W-1:0]  command;
    logic signed [DUTY_W-1:0] duty;
    logic                     clipped;
  } ctrl_result_t;

  logic                        clk             = 1'b0;
  logic                        rst_n           = 1'b0;
  logic                        in_valid        = 1'b0;
  logic                        in_stall;
  logic signed [COUNT_W-1:0]   in_count_sample = '0;
  logic                        out_valid;
  logic                        out_stall       = 1'b0;
  logic signed [CMD_W-1:0]     out_command;
  logic signed [DUTY_W-1:0]    out_duty;
  logic                        out_clipped;
  logic                        cfg_wr_en       = 1'b0;
  bqpc_reg_idx_t               cfg_index       = REG_B0;
  logic [CFG_W-1:0]            cfg_wr_data     = '0;

  // Shadow copy of the controller registers and filter history
  logic signed [COEF_W-1:0] m_b0, m_b1, m_b2, m_a1, m_a2;
  logic signed [POS_W-1:0]  m_setpoint;
  logic [VLIM_W-1:0]        m_vlimit;
  logic [CFG_W-1:0]         m_rpc;
  longint                   err_hist1, err_hist2, cmd_hist1, cmd_hist2;

  logic signed [COUNT_W-1:0] pending_counts[$];
  ctrl_result_t              cmd_expected_q[$];
  int                        send_idle_pct  = 0;
  int                        recv_stall_pct = 0;
  int                        mismatches     = 0;
  int                        idle_cycles    = 0;

  biquad_position_controller dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_count_sample (in_count_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_command     (out_command),
    .out_duty        (out_duty),
    .out_clipped     (out_clipped),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Run one filter step on the shadow state and queue the command it yields
  function automatic void predict_command(logic signed [COUNT_W-1:0] cnt);
    longint          pos, err, acc, u, vmax, duty_v;
    longint unsigned mag, ratio, vden;
    logic            clip;
    ctrl_result_t    r;
    pos  = clamp32((longint'(cnt) * longint'(m_rpc)) >>> 16);
    err  = clamp32(longint'(m_setpoint) - pos);
    acc  = longint'(m_b0) * err + longint'(m_b1) * err_hist1 + longint'(m_b2) * err_hist2
         - longint'(m_a1) * cmd_hist1 - longint'(m_a2) * cmd_hist2;
    u    = acc >>> 12;
    vmax = longint'(m_vlimit);
    vden = m_vlimit;
    clip = 1'b0;
    if (u > vmax) begin
      u    = vmax;
      clip = 1'b1;
    end
    if (u < -vmax) begin
      u    = -vmax;
      clip = 1'b1;
    end
    // Zero limit forces a zero duty
    if (vmax == 0) begin
      duty_v = 0;
    end else begin
      mag   = (u < 0) ? -u : u;
      ratio = (mag << 15) / vden;
      if (ratio > 32767) ratio = 32767;
      duty_v = (u < 0) ? -longint'(ratio) : longint'(ratio);
    end
    err_hist2 = err_hist1;
    err_hist1 = err;
    cmd_hist2 = cmd_hist1;
    cmd_hist1 = u;
    r.command = u[CMD_W-1:0];
    r.duty    = duty_v[DUTY_W-1:0];
    r.clipped = clip;
    cmd_expected_q.push_back(r);
  endfunction

  function automatic logic signed [COUNT_W-1:0] rand_count();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1: v = int'($urandom_range(0, 8191)) - 4096;
      2: v = $urandom_range(0, 1) ? 8388607 - int'($urandom_range(0, 15))
                                  : -8388608 + int'($urandom_range(0, 15));
      default: v = int'($urandom_range(0, 2047)) - 1024;
    endcase
    return v[COUNT_W-1:0];
  endfunction

  function automatic logic [CFG_W-1:0] rand_coef();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1, 2: v = int'($urandom_range(0, 8191)) - 4096;
      default: v = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    return v;
  endfunction

  // Write one register; the shadow copy follows with the same masking
  task automatic write_reg(bqpc_reg_idx_t idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    case (idx)
      REG_B0:       m_b0       = data[COEF_W-1:0];
      REG_B1:       m_b1       = data[COEF_W-1:0];
      REG_B2:       m_b2       = data[COEF_W-1:0];
      REG_A1:       m_a1       = data[COEF_W-1:0];
      REG_A2:       m_a2       = data[COEF_W-1:0];
      REG_SETPOINT: m_setpoint = data[POS_W-1:0];
      REG_VLIMIT:   m_vlimit   = data[VLIM_W-1:0];
      REG_RPC:      m_rpc      = data[CFG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_coefs(logic [CFG_W-1:0] b0, logic [CFG_W-1:0] b1,
                             logic [CFG_W-1:0] b2, logic [CFG_W-1:0] a1,
                             logic [CFG_W-1:0] a2);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
  endtask

  // Block until every queued sample is in and every command is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_counts.size() != 0 || in_valid || cmd_expected_q.size() != 0);
  endtask

  // Sample driver: hold a stalled transaction, otherwise present the next count
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_command(in_count_sample);
      if (!in_valid || !in_stall) begin
        if (pending_counts.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid        <= 1'b1;
          in_count_sample <= pending_counts.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Command monitor: compare each accepted transaction, then pick the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cmd_expected_q.size() == 0) begin
          $error("command %0d arrived with no sample outstanding", out_command);
          mismatches++;
        end else begin
          if (out_command !== cmd_expected_q[0].command) begin
            $error("command: expected %0d, got %0d", cmd_expected_q[0].command, out_command);
            mismatches++;
          end
          if (out_duty !== cmd_expected_q[0].duty) begin
            $error("duty: expected %0d, got %0d", cmd_expected_q[0].duty, out_duty);
            mismatches++;
          end
          if (out_clipped !== cmd_expected_q[0].clipped) begin
            $error("clipped: expected %0d, got %0d", cmd_expected_q[0].clipped, out_clipped);
            mismatches++;
          end
          void'(cmd_expected_q.pop_front());
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: give up after a long run of cycles with no transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("biquad_position_controller verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int p;
    m_b0 = RST_B0;
    m_b1 = RST_B1;
    m_b2 = RST_B2;
    m_a1 = RST_A1;
    m_a2 = RST_A2;
    m_setpoint = RST_SP;
    m_vlimit   = RST_VLIM;
    m_rpc      = RST_RPC;
    err_hist1 = 0;
    err_hist2 = 0;
    cmd_hist1 = 0;
    cmd_hist2 = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: count extremes and small steps around the setpoint
    pending_counts = '{0, 0, 8388607, -8388608, 1, -1, 652, -652, 4096, 0};
    wait_drained();

    // Full-scale gains, most negative setpoint, widest scale: position and error saturate
    write_coefs(32767, -32768, 32767, -32768, 32767);
    write_reg(REG_SETPOINT, 32'h8000_0000);
    write_reg(REG_VLIMIT, 32'h00FF_FFFF);
    write_reg(REG_RPC, 32'hFFFF_FFFF);
    pending_counts = '{8388607, -8388608, 8388607, 0, 1, -1};
    wait_drained();

    // Opposite extremes, unit limit: error saturates upward, command clips
    write_coefs(-32768, 32767, -32768, 32767, -32768);
    write_reg(REG_SETPOINT, 32'h7FFF_FFFF);
    write_reg(REG_VLIMIT, 32'd1);
    pending_counts = '{-8388608, 8388607, 0, 5};
    wait_drained();

    // Zero limit and zero scale
    write_coefs(RST_B0, RST_B1, RST_B2, RST_A1, RST_A2);
    write_reg(REG_SETPOINT, RST_SP);
    write_reg(REG_VLIMIT, 32'd0);
    write_reg(REG_RPC, 32'd0);
    pending_counts = '{300, -300, 0};
    wait_drained();

    // Random settings under each pacing mode
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (p % 3 == 0)
        write_coefs(RST_B0, RST_B1, RST_B2, RST_A1, RST_A2);
      else
        write_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
      case ($urandom_range(0, 2))
        0: write_reg(REG_SETPOINT, $urandom());
        1: write_reg(REG_SETPOINT, $urandom_range(0, 1 << 20) - (1 << 19));
        default: write_reg(REG_SETPOINT, 32'd0);
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_VLIMIT, $urandom_range(1, 24'hFF_FFFF));
        1: write_reg(REG_VLIMIT, $urandom_range(1, 1 << 20));
        2: write_reg(REG_VLIMIT, $urandom_range(0, 1) ? 32'd1 : 32'h00FF_FFFF);
        default: write_reg(REG_VLIMIT, $urandom_range(65536, 1 << 22));
      endcase
      case ($urandom_range(0, 2))
        0: write_reg(REG_RPC, $urandom());
        1: write_reg(REG_RPC, $urandom_range(0, 1 << 24));
        default: write_reg(REG_RPC, RST_RPC);
      endcase
      repeat (PHASE_ITEMS) pending_counts.push_back(rand_count());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (cmd_expected_q.size() != 0) begin
      $error("%0d commands never arrived", cmd_expected_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("biquad_position_controller verification clean");
    end else begin
      $display("biquad_position_controller verification failed");
    end
    $finish;
  end

endmodule
